[sv/sclm_pkg.sv]
package sclm_pkg;

  localparam int NODES = 1024;
  localparam int NODE_W = $clog2(NODES);
  localparam int LEN_W = 11;
  localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // memoized length plus the mark of the running query
  typedef struct packed {
    logic visited;
    len_t len;
  } entry_t;

  typedef struct packed {
    logic   succ_we;
    node_t  succ_addr;
    node_t  succ_data;
    logic   len_we;
    node_t  len_addr;
    entry_t len_data;
    node_t  raddr;
  } mem_req_t;

  typedef struct packed {
    node_t  next;
    entry_t ent;
  } mem_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_CYCLE,
    ST_UNWIND,
    ST_FINISH
  } state_t;

endpackage

[sv/sclm_in_if.sv]
interface sclm_in_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  sclm_pkg::node_t      node;
  sclm_pkg::node_t      successor;

  modport source (output valid, output func, output node, output successor, input ready);
  modport sink (input valid, input func, input node, input successor, output ready);
endinterface

[sv/sclm_out_if.sv]
interface sclm_out_if;
  logic                 valid;
  logic                 ready;
  sclm_pkg::len_t       chain_length;

  modport source (output valid, output chain_length, input ready);
  modport sink (input valid, input chain_length, output ready);
endinterface

[sv/sclm_store.sv]
module sclm_store (
  input  logic               clk,
  input  sclm_pkg::mem_req_t req,
  output sclm_pkg::mem_rsp_t rsp
);

  sclm_pkg::node_t  succ_mem [sclm_pkg::NODES];
  sclm_pkg::entry_t len_mem  [sclm_pkg::NODES];

  sclm_pkg::node_t  rd_next_r;
  sclm_pkg::entry_t rd_ent_r;

  always_ff @(posedge clk) begin
    if (req.succ_we) begin
      succ_mem[req.succ_addr] <= req.succ_data;
    end
    rd_next_r <= succ_mem[req.raddr];
  end

  // a walk may read the entry it writes in the same cycle: forward the new value
  always_ff @(posedge clk) begin
    if (req.len_we) begin
      len_mem[req.len_addr] <= req.len_data;
    end
    if (req.len_we && (req.len_addr == req.raddr)) begin
      rd_ent_r <= req.len_data;
    end else begin
      rd_ent_r <= len_mem[req.raddr];
    end
  end

  assign rsp.next = rd_next_r;
  assign rsp.ent  = rd_ent_r;

endmodule

[sv/sclm_walk.sv]
module sclm_walk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  sclm_pkg::node_t    in_node,
  input  sclm_pkg::node_t    in_successor,
  output logic               out_valid,
  input  logic               out_ready,
  output sclm_pkg::len_t     out_chain_length,
  output sclm_pkg::mem_req_t req,
  input  sclm_pkg::mem_rsp_t rsp
);

  sclm_pkg::state_t state_r, state_nxt;
  sclm_pkg::node_t  clr_addr_r, clr_addr_nxt;
  sclm_pkg::node_t  start_r, start_nxt;
  sclm_pkg::node_t  cur_r, cur_nxt;
  sclm_pkg::node_t  stop_r, stop_nxt;
  sclm_pkg::len_t   cnt_r, cnt_nxt;
  sclm_pkg::len_t   cyc_r, cyc_nxt;
  sclm_pkg::len_t   res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  sclm_pkg::len_t   out_len_r, out_len_nxt;

  logic             in_xfer;
  logic             stop_hit;
  logic             slot_free;
  sclm_pkg::len_t   cyc_len;
  logic [sclm_pkg::LEN_W:0] tail_sum;
  sclm_pkg::len_t   tail_len;

  assign in_ready  = (state_r == sclm_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign stop_hit  = (cur_r == '0) || (rsp.ent.len != '0);
  assign cyc_len   = cnt_r - rsp.ent.len + sclm_pkg::len_t'(1);
  assign tail_sum  = {1'b0, cnt_r} + {1'b0, rsp.ent.len};
  assign tail_len  = tail_sum[sclm_pkg::LEN_W] ? sclm_pkg::LEN_SAT
                                               : tail_sum[sclm_pkg::LEN_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sclm_pkg::ST_CLEAR: begin
        if (clr_addr_r == '1) state_nxt = sclm_pkg::ST_IDLE;
      end
      sclm_pkg::ST_IDLE: begin
        if (in_xfer && (in_func == sclm_pkg::FUNC_QUERY)) state_nxt = sclm_pkg::ST_WALK;
      end
      sclm_pkg::ST_WALK: begin
        if (stop_hit) begin
          if ((cur_r != '0) && rsp.ent.visited) state_nxt = sclm_pkg::ST_CYCLE;
          else state_nxt = sclm_pkg::ST_UNWIND;
        end
      end
      sclm_pkg::ST_CYCLE: begin
        if (cur_r == stop_r) state_nxt = sclm_pkg::ST_UNWIND;
      end
      sclm_pkg::ST_UNWIND: begin
        if (cur_r == stop_r) state_nxt = sclm_pkg::ST_FINISH;
      end
      sclm_pkg::ST_FINISH: begin
        if (slot_free) state_nxt = sclm_pkg::ST_IDLE;
      end
      default: state_nxt = sclm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    stop_nxt      = stop_r;
    cnt_nxt       = cnt_r;
    cyc_nxt       = cyc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_len_nxt   = out_len_r;
    req           = '0;
    req.raddr     = rsp.next;
    unique case (state_r)
      sclm_pkg::ST_CLEAR: begin
        req.succ_we   = 1'b1;
        req.succ_addr = clr_addr_r;
        req.len_we    = 1'b1;
        req.len_addr  = clr_addr_r;
        clr_addr_nxt  = clr_addr_r + sclm_pkg::node_t'(1);
      end
      sclm_pkg::ST_IDLE: begin
        req.raddr = in_node;
        if (in_xfer) begin
          if (in_func == sclm_pkg::FUNC_LOAD) begin
            req.succ_we   = 1'b1;
            req.succ_addr = in_node;
            req.succ_data = in_successor;
          end else begin
            start_nxt = in_node;
            cur_nxt   = in_node;
            cnt_nxt   = '0;
          end
        end
      end
      sclm_pkg::ST_WALK: begin
        if (!stop_hit) begin
          // number the node and move on
          req.len_we   = 1'b1;
          req.len_addr = cur_r;
          req.len_data = '{visited: 1'b1, len: cnt_r + sclm_pkg::len_t'(1)};
          cnt_nxt      = cnt_r + sclm_pkg::len_t'(1);
          cur_nxt      = rsp.next;
        end else begin
          stop_nxt = cur_r;
          if (cur_r == '0) begin
            res_nxt   = cnt_r;
            cur_nxt   = start_r;
            req.raddr = start_r;
          end else if (rsp.ent.visited) begin
            // closed a loop: stamp the cycle length around it
            req.len_we   = 1'b1;
            req.len_addr = cur_r;
            req.len_data = '{visited: 1'b0, len: cyc_len};
            cyc_nxt      = cyc_len;
            res_nxt      = (cur_r == start_r) ? cyc_len : cnt_r;
            cur_nxt      = rsp.next;
          end else begin
            cnt_nxt   = tail_len;
            res_nxt   = tail_len;
            cur_nxt   = start_r;
            req.raddr = start_r;
          end
        end
      end
      sclm_pkg::ST_CYCLE: begin
        if (cur_r == stop_r) begin
          cur_nxt   = start_r;
          req.raddr = start_r;
        end else begin
          req.len_we   = 1'b1;
          req.len_addr = cur_r;
          req.len_data = '{visited: 1'b0, len: cyc_r};
          cur_nxt      = rsp.next;
        end
      end
      sclm_pkg::ST_UNWIND: begin
        // prefix becomes distance to the end, marks cleared on the way
        if (cur_r != stop_r) begin
          req.len_we   = 1'b1;
          req.len_addr = cur_r;
          req.len_data = '{visited: 1'b0, len: cnt_r};
          cnt_nxt      = (cnt_r != '0) ? cnt_r - sclm_pkg::len_t'(1) : cnt_r;
          cur_nxt      = rsp.next;
        end
      end
      sclm_pkg::ST_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = res_r;
        end
      end
      default: begin
        clr_addr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sclm_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r   <= start_nxt;
    cur_r     <= cur_nxt;
    stop_r    <= stop_nxt;
    cnt_r     <= cnt_nxt;
    cyc_r     <= cyc_nxt;
    res_r     <= res_nxt;
    out_len_r <= out_len_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_chain_length = out_len_r;

endmodule

[sv/successor_chain_length_memo.sv]
// Memoized chain length over a successor table of 1024 nodes (node 0 = no successor).
// in_ch carries transactions with func, node and successor: func load writes the
// successor of node, func query asks for the chain length from node.
// out_ch returns one chain_length per query and nothing for a load.
// Loads may follow back to back.
// A query reads the memo entry of its start node; on a hit the result passes through
// the WALK, UNWIND and FINISH states into the output register. On a miss it walks
// forward one node per cycle, stamps a found cycle one node per cycle, then rewrites
// the walked prefix one node per cycle. The single read port of the node memories
// sets this pace.
// in_ch.ready stays low for the whole query.
// A result waits in the output register; a new transaction is taken while it waits,
// but a further query finishes only after out_ch has taken the earlier result.
// After reset a clearing pass over all 1024 nodes zeroes the successor and length
// memories; in_ch.ready stays low until it ends.
module successor_chain_length_memo (
  input  logic       clk,
  input  logic       rst_n,
  sclm_in_if.sink    in_ch,
  sclm_out_if.source out_ch
);

  sclm_pkg::mem_req_t mem_req;
  sclm_pkg::mem_rsp_t mem_rsp;

  sclm_walk u_walk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_func          (in_ch.func),
    .in_node          (in_ch.node),
    .in_successor     (in_ch.successor),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_chain_length (out_ch.chain_length),
    .req              (mem_req),
    .rsp              (mem_rsp)
  );

  sclm_store u_store (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

endmodule

[sv/sclm_checker.sv]
module sclm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_func,
  input logic out_valid,
  input logic out_ready
);

  // clearing pass holds off input after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == sclm_pkg::FUNC_QUERY)) |=> !in_ready)
    else $error("input still ready after a query transaction");

  a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == sclm_pkg::FUNC_LOAD)) |=> in_ready)
    else $error("load transaction stalled the input");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind successor_chain_length_memo sclm_checker u_sclm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
